FILE: rtl/bwc_pkg.sv
// bwc_pkg: shared types, constants and helpers of the white blob centroid steering core
// no dependencies; imported by every module of the block
package bwc_pkg;

  // configuration port
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_MAX = 8191;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // payload widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned MEAN_W = 12;
  localparam int unsigned CNT_W  = 23;
  localparam int unsigned SUM_W  = CNT_W + MEAN_W;
  localparam int unsigned TW     = 13;
  localparam int unsigned DIR_W  = 2;

  localparam logic [CHAN_W-1:0] WHITE_LEVEL = '1;

  // quotient steps of the centroid divider: one saturation bit plus the mean bits
  localparam int unsigned STEP_N = MEAN_W + 1;
  localparam int unsigned STEP_W = $clog2(STEP_N);

  // frame queue between the accumulator and the divider (power of two deep)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP    = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_FORWARD = 2'd3
  } dir_e;

  // configuration write strobe
  typedef struct packed {
    logic             en;
    logic             idx;
    logic [CFG_W-1:0] data;
  } cfg_wr_t;

  // steering thresholds: width/3 and 2*width/3
  typedef struct packed {
    logic [TW-1:0] w3;
    logic [TW-1:0] w23;
  } thr_t;

  // one finished frame waiting for the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    thr_t             thr;
  } job_t;

endpackage

FILE: rtl/bwc_bounds.sv
// bwc_bounds: configuration registers and frame geometry (scan bounds, steering thresholds)
// depends on bwc_pkg; one multiply, then reciprocal multiplies for the divides by three
module bwc_bounds import bwc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned WE = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX,
  localparam int unsigned HE = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX,
  localparam int unsigned WW = $clog2(WE + 1),
  localparam int unsigned HW = $clog2(HE + 1),
  localparam int unsigned PW = $clog2(WE * HE + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_wr_i,
  output logic [CFG_W-1:0] width_o,
  output logic [CFG_W-1:0] height_o,
  output logic             busy_o,
  output logic [PW-1:0]    n_o,
  output logic [PW-1:0]    lo_o,
  output logic [PW-1:0]    hi_o,
  output logic [WW-1:0]    w_o,
  output thr_t             thr_o
);

  // reciprocals of three: exact for 32-bit and 16-bit dividends
  localparam logic [31:0] RECIP_N = 32'hAAAA_AAAB;
  localparam logic [15:0] RECIP_W = 16'hAAAB;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIX  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] width_q, height_q;
  logic [WW-1:0]    weff, w_q;
  logic [HW-1:0]    heff;
  logic [WW+HW-1:0] prod;
  logic [PW-1:0]    n_q, lo_q, hi_q, lo2, n_rem;
  logic [TW-1:0]    w3_q, w23_q, w32, w_rem;
  logic [63:0]      n_mul;
  logic [31:0]      w_mul;

  // registers clamped to the supported range
  assign weff = (width_q == '0) ? WW'(1) :
                (width_q > CFG_W'(WE)) ? WW'(WE) : WW'(width_q);
  assign heff = (height_q == '0) ? HW'(1) :
                (height_q > CFG_W'(HE)) ? HW'(HE) : HW'(height_q);
  assign prod = weff * heff;

  // quotients by reciprocal multiply, then twice the quotient plus a remainder fix
  assign n_mul = 64'(32'(n_q)) * 64'(RECIP_N);
  assign w_mul = 32'(w_q) * 32'(RECIP_W);
  assign lo2   = {lo_q[PW-2:0], 1'b0};
  assign n_rem = n_q - lo2 - lo_q;
  assign w32   = {w3_q[TW-2:0], 1'b0};
  assign w_rem = TW'(w_q) - w32 - w3_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_wr_i.en) begin
      unique case (cfg_wr_i.idx)
        REG_WIDTH:  width_q  <= cfg_wr_i.data;
        REG_HEIGHT: height_q <= cfg_wr_i.data;
        default:    width_q  <= width_q;
      endcase
    end
  end

  // sequencer: any write restarts the geometry computation
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_FIX;
      ST_FIX:  state_d = ST_IDLE;
    endcase
    if (cfg_wr_i.en) begin
      state_d = ST_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MUL;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath: product, then thirds, then two thirds
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      n_q <= PW'(prod);
      w_q <= weff;
    end
    if (state_q == ST_DIV) begin
      lo_q <= n_mul[PW+32:33];
      w3_q <= w_mul[TW+16:17];
    end
    if (state_q == ST_FIX) begin
      hi_q  <= lo2 + PW'(n_rem == PW'(2));
      w23_q <= w32 + TW'(w_rem == TW'(2));
    end
  end

  assign width_o   = width_q;
  assign height_o  = height_q;
  assign busy_o    = (state_q != ST_IDLE);
  assign n_o       = n_q;
  assign lo_o      = lo_q;
  assign hi_o      = hi_q;
  assign w_o       = w_q;
  assign thr_o.w3  = w3_q;
  assign thr_o.w23 = w23_q;

endmodule

FILE: rtl/bwc_front.sv
// bwc_front: pixel intake, white test in the middle third, column sum and count
// depends on bwc_pkg; pushes one job per frame into the frame queue
module bwc_front import bwc_pkg::*; #(
  parameter int unsigned PW = 25,
  parameter int unsigned WW = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic              frame_end_i,
  input  logic              busy_i,
  input  logic [PW-1:0]     n_i,
  input  logic [PW-1:0]     lo_i,
  input  logic [PW-1:0]     hi_i,
  input  logic [WW-1:0]     w_i,
  input  thr_t              thr_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output job_t              job_o
);

  logic [PW-1:0]    pix_q, pix_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] white_q, white_nx, white_d;
  logic [SUM_W-1:0] sum_q, sum_nx, sum_d;
  logic [SUM_W:0]   sum_ext;
  logic [TW-1:0]    col_inc;
  logic             accept, hit;

  assign in_ready_o = !busy_i && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // white pixel inside the scanned region
  assign hit = (pix_q >= lo_i) && (pix_q < hi_i) &&
               (red_i == WHITE_LEVEL) && (green_i == WHITE_LEVEL) &&
               (blue_i == WHITE_LEVEL);

  // saturating count and column sum
  assign sum_ext  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(col_q);
  assign white_nx = (hit && (white_q != '1)) ? white_q + CNT_W'(1) : white_q;
  assign sum_nx   = !hit ? sum_q : (sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0]);

  // raster position
  assign col_inc = TW'(col_q) + TW'(1);

  always_comb begin
    pix_d   = pix_q;
    col_d   = col_q;
    white_d = white_q;
    sum_d   = sum_q;
    if (accept) begin
      if (frame_end_i) begin
        pix_d   = '0;
        col_d   = '0;
        white_d = '0;
        sum_d   = '0;
      end else begin
        pix_d   = (pix_q < n_i) ? pix_q + PW'(1) : pix_q;
        col_d   = (col_inc >= TW'(w_i)) ? '0 : col_inc[COL_W-1:0];
        white_d = white_nx;
        sum_d   = sum_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q   <= '0;
      col_q   <= '0;
      white_q <= '0;
      sum_q   <= '0;
    end else begin
      pix_q   <= pix_d;
      col_q   <= col_d;
      white_q <= white_d;
      sum_q   <= sum_d;
    end
  end

  // last pixel of the frame hands the totals to the divider
  assign push_valid_o = accept && frame_end_i;
  assign job_o.sum    = sum_nx;
  assign job_o.count  = white_nx;
  assign job_o.thr    = thr_i;

endmodule

FILE: rtl/bwc_fifo.sv
// bwc_fifo: short frame queue between the pixel accumulator and the divider
// depends on bwc_pkg (job_t, QDEPTH)
module bwc_fifo import bwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  job_t           mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + QAW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QAW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/bwc_back.sv
// bwc_back: restoring divider for the mean column, steering decision, output register
// depends on bwc_pkg; takes one job from the frame queue at a time
module bwc_back import bwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  job_t              job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIR_W-1:0]  direction_o,
  output logic [MEAN_W-1:0] mean_column_o,
  output logic [CNT_W-1:0]  white_total_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  rem_q, dvs_q;
  logic [STEP_N-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  thr_t              thr_q;
  logic              out_valid_q, out_valid_d;
  logic              take, ge, out_free, load;
  logic [MEAN_W-1:0] mean;
  dir_e              dir;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign take        = pop_valid_i && pop_ready_o;
  assign ge          = (rem_q >= dvs_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign load        = (state_q == ST_DONE) && out_free;

  // mean saturates when the quotient reaches 4096
  assign mean = quo_q[STEP_N-1] ? '1 : quo_q[MEAN_W-1:0];

  // steering decision
  always_comb begin
    priority if (cnt_q == '0) begin
      dir = DIR_STOP;
    end else if (TW'(mean) < thr_q.w3) begin
      dir = DIR_LEFT;
    end else if (TW'(mean) > thr_q.w23) begin
      dir = DIR_RIGHT;
    end else begin
      dir = DIR_FORWARD;
    end
  end

  // control sequence
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (take) begin
          state_d = (job_i.count == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEP_N - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // divider datapath, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (take) begin
      rem_q <= job_i.sum;
      dvs_q <= {job_i.count, {MEAN_W{1'b0}}};
      quo_q <= '0;
      cnt_q <= job_i.count;
      thr_q <= job_i.thr;
    end else if (state_q == ST_DIV) begin
      rem_q <= ge ? rem_q - dvs_q : rem_q;
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[STEP_N-2:0], ge};
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      direction_o   <= dir;
      mean_column_o <= mean;
      white_total_o <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/white_blob_centroid_steer_core.sv
// white_blob_centroid_steer_core: top level of the white blob centroid steering core
// depends on bwc_pkg, bwc_bounds, bwc_front, bwc_fifo, bwc_back
//
// Takes one RGB pixel per cycle in raster order while in_ready_o is high; pure white
// pixels in the middle third of the frame (pixel index from floor(N/3) to floor(2N/3)-1)
// add their column to a sum and a count, and the pixel flagged frame_end yields one
// command: stop, left, right or forward from the truncated mean column against width/3
// and 2*width/3; in_ready_o can drop inside a frame. After reset and after every register
// write the input is held off while the frame size is multiplied out and divided by three
// with reciprocal multiplies. Each finished frame passes through a two-entry queue into a
// restoring divider that takes one frame at a time (13 quotient bits, take, hand-off), so
// frames that come faster than it clears them are held back only once the queue fills.
module white_blob_centroid_steer_core import bwc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // pixel stream
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic              frame_end_i,
  // steering command
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIR_W-1:0]  direction_o,
  output logic [MEAN_W-1:0] mean_column_o,
  output logic [CNT_W-1:0]  white_total_o
);

  localparam int unsigned WE = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
  localparam int unsigned HE = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
  localparam int unsigned WW = $clog2(WE + 1);
  localparam int unsigned PW = $clog2(WE * HE + 1);

  cfg_wr_t          cfg_wr;
  logic [CFG_W-1:0] width, height;
  logic             busy;
  logic [PW-1:0]    n, lo, hi;
  logic [WW-1:0]    w;
  thr_t             thr;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  job_t             push_job, pop_job;

  // register access
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata[CFG_W-1:0];

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = DATA_W'(width);
      REG_HEIGHT: prdata = DATA_W'(height);
      default:    prdata = '0;
    endcase
  end

  bwc_bounds #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_bounds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .width_o  (width),
    .height_o (height),
    .busy_o   (busy),
    .n_o      (n),
    .lo_o     (lo),
    .hi_o     (hi),
    .w_o      (w),
    .thr_o    (thr)
  );

  bwc_front #(
    .PW (PW),
    .WW (WW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .frame_end_i  (frame_end_i),
    .busy_i       (busy),
    .n_i          (n),
    .lo_i         (lo),
    .hi_i         (hi),
    .w_i          (w),
    .thr_i        (thr),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .job_o        (push_job)
  );

  bwc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  bwc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .job_i         (pop_job),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .direction_o   (direction_o),
    .mean_column_o (mean_column_o),
    .white_total_o (white_total_o)
  );

endmodule

FILE: rtl/bwc_checker.sv
// bwc_checker: port-level checks of the white blob centroid steering core
// depends on bwc_pkg; bound to white_blob_centroid_steer_core below
module bwc_checker import bwc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DIR_W-1:0]  direction_o,
  input logic [MEAN_W-1:0] mean_column_o,
  input logic [CNT_W-1:0]  white_total_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(direction_o) &&
      $stable(mean_column_o) && $stable(white_total_o))
    else $error("result changed while stalled");

  // stop exactly when no white pixel was found
  a_stop_iff_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((direction_o == DIR_STOP) == (white_total_o == '0)))
    else $error("stop command does not match white count");

  // stop carries a zero mean
  a_stop_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (direction_o == DIR_STOP) |-> (mean_column_o == '0))
    else $error("stop command with nonzero mean");

  // a register write holds off pixels while the bounds are recomputed
  a_cfg_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !in_ready_o)
    else $error("pixels accepted right after a register write");

endmodule

bind white_blob_centroid_steer_core bwc_checker u_bwc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .direction_o   (direction_o),
  .mean_column_o (mean_column_o),
  .white_total_o (white_total_o)
);
